### src/hlg_pkg.sv
// Package for the Huber loss and gradient block: widths, register codes,
// reset values and the sequencer state type. No dependencies.
`default_nettype none

package hlg_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int IO_W       = 32;   // prediction, target, gradient
    localparam int DELTA_W    = 31;
    localparam int ROWS_W     = 16;
    localparam int LOSS_W     = 31;
    localparam int ACC_W      = 64;
    localparam int MUL_W      = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HUBER_DELTA = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_ROWS  = CFG_IDX_W'(1);

    localparam logic [DELTA_W-1:0] DELTA_RESET = DELTA_W'(65536);
    localparam logic [ROWS_W-1:0]  ROWS_RESET  = ROWS_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_MUL_A,
        S_MUL_B,
        S_ELEM,
        S_ACC,
        S_DIV_G,
        S_DIV_L,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

### src/hlg_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on hlg_pkg for the operand width default.
`default_nettype none

module hlg_mul #(
    parameter int W = hlg_pkg::MUL_W
) (
    input  wire logic           i_clk,
    input  wire logic [W-1:0]   i_a,
    input  wire logic [W-1:0]   i_b,
    output logic      [2*W-1:0] o_prod
);

    logic [2*W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= (2*W)'(i_a) * (2*W)'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

### src/hlg_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Runs a full-width or a half-width dividend; depends on hlg_pkg.
`default_nettype none

module hlg_div #(
    parameter int DIVIDEND_W = hlg_pkg::ACC_W,
    parameter int DIVISOR_W  = hlg_pkg::ROWS_W
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_long,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic      [DIVIDEND_W-1:0] o_quotient
);

    localparam int HALF  = DIVIDEND_W / 2;
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVISOR_W:0]    w_shift;
    logic [DIVISOR_W:0]    w_sub;
    logic                  w_ge;
    logic [DIVISOR_W-1:0]  n_rem;

    always_comb begin
        w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
        w_sub   = w_shift - {1'b0, r_dvs};
        w_ge    = (w_shift >= {1'b0, r_dvs});
        n_rem   = w_ge ? w_sub[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_long ? CNT_W'(DIVIDEND_W) : CNT_W'(HALF);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // zero row count divides as one
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= (i_divisor == '0) ? DIVISOR_W'(1) : i_divisor;
            r_quo <= i_long ? i_dividend
                            : {i_dividend[HALF-1:0], {(DIVIDEND_W-HALF){1'b0}}};
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### src/huber_loss_and_gradient.sv
// Top level of the Huber loss and gradient block: sequencer, datapath
// registers and config registers. Uses hlg_pkg, hlg_mul and hlg_div.
//
//  channel   dir  handshake                      payload
//  --------  ---  -----------------------------  ---------------------------------
//  in        in   i_in_valid / o_in_stall        i_prediction i_target i_last_in_batch
//  out       out  o_out_valid / i_out_stall      o_gradient o_batch_loss o_last_out
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index i_cfg_data
//
// The block takes one word at a time: the input stalls from accept until the
// result is loaded into the output register. The radix-2 divider runs 32
// steps for the gradient and 64 more for the batch loss on a word marked last.
// Reset is synchronous, active low; it clears the sequencer, the accumulator
// and the registers to delta 1.0 and one row. A stalled result sits in the
// output register while the next word is accepted and worked on.
`default_nettype none

module huber_loss_and_gradient #(
    parameter int FRAC_BITS  = hlg_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = hlg_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input words
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [hlg_pkg::IO_W-1:0]    i_prediction,
    input  wire logic signed [hlg_pkg::IO_W-1:0]    i_target,
    input  wire logic                               i_last_in_batch,
    // result words
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed      [hlg_pkg::IO_W-1:0]    o_gradient,
    output logic             [hlg_pkg::LOSS_W-1:0]  o_batch_loss,
    output logic                                    o_last_out,
    // config writes
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic        [hlg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic        [hlg_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IO_W    = hlg_pkg::IO_W;
    localparam int DELTA_W = hlg_pkg::DELTA_W;
    localparam int ROWS_W  = hlg_pkg::ROWS_W;
    localparam int LOSS_W  = hlg_pkg::LOSS_W;
    localparam int ACC_W   = hlg_pkg::ACC_W;
    localparam int MUL_W   = hlg_pkg::MUL_W;
    localparam int SAT_BITS = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

    // signed saturation bounds on a 33-bit difference
    localparam logic signed [IO_W:0] D_MAX = (IO_W+1)'((34'sd1 <<< (SAT_BITS - 1)) - 34'sd1);
    localparam logic signed [IO_W:0] D_MIN = -D_MAX - (IO_W+1)'(1);
    // element loss bound
    localparam logic [ACC_W:0]   ELEM_MAX  = (ACC_W+1)'((65'd1 << (SAT_BITS - 1)) - 65'd1);
    localparam logic [LOSS_W-1:0] LOSS_MAX = '1;

    hlg_pkg::t_state r_state, n_state;

    // config registers
    logic [DELTA_W-1:0] r_delta;
    logic [ROWS_W-1:0]  r_rows;

    // per-word working registers
    logic signed [IO_W-1:0] r_pred;
    logic signed [IO_W-1:0] r_tgt;
    logic                   r_last;
    logic                   r_neg;
    logic                   r_in_rng;
    logic [MUL_W-1:0]       r_mag;
    logic [2*MUL_W-1:0]     r_p1;
    logic [LOSS_W-1:0]      r_elem;
    logic [ACC_W-1:0]       r_acc;
    logic signed [IO_W-1:0] r_grad;

    // output register
    logic                   r_out_valid;
    logic signed [IO_W-1:0] r_out_grad;
    logic [LOSS_W-1:0]      r_out_loss;
    logic                   r_out_last;

    // sequencer outputs
    logic w_accept;
    logic w_mul_sq;      // first multiply: |d|^2 or delta * |d|
    logic w_div_start;
    logic w_div_long;
    logic w_out_load;
    logic w_out_free;

    // datapath
    logic signed [IO_W:0]   w_raw;
    logic signed [IO_W:0]   w_d;
    logic signed [IO_W:0]   w_abs;
    logic [MUL_W-1:0]       w_mul_a;
    logic [MUL_W-1:0]       w_mul_b;
    logic [2*MUL_W-1:0]     w_prod;
    logic [ACC_W:0]         w_full;
    logic [ACC_W:0]         w_shr;
    logic [ACC_W:0]         w_sum;
    logic [ACC_W-1:0]       w_div_in;
    logic                   w_div_done;
    logic [ACC_W-1:0]       w_quo;
    logic signed [IO_W:0]   w_gs;
    logic signed [IO_W:0]   w_gsat;
    logic [MUL_W-1:0]       w_delta_ext;

    assign w_delta_ext = {1'b0, r_delta};
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            hlg_pkg::S_IDLE:  if (i_in_valid) n_state = hlg_pkg::S_DIFF;
            hlg_pkg::S_DIFF:  n_state = hlg_pkg::S_MUL_A;
            hlg_pkg::S_MUL_A: n_state = hlg_pkg::S_MUL_B;
            hlg_pkg::S_MUL_B: n_state = hlg_pkg::S_ELEM;
            hlg_pkg::S_ELEM:  n_state = hlg_pkg::S_ACC;
            hlg_pkg::S_ACC:   n_state = hlg_pkg::S_DIV_G;
            hlg_pkg::S_DIV_G: begin
                if (w_div_done) begin
                    n_state = r_last ? hlg_pkg::S_DIV_L : hlg_pkg::S_OUT;
                end
            end
            hlg_pkg::S_DIV_L: if (w_div_done) n_state = hlg_pkg::S_OUT;
            hlg_pkg::S_OUT:   if (w_out_free) n_state = hlg_pkg::S_IDLE;
            default:          n_state = hlg_pkg::S_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        o_in_stall  = 1'b1;
        w_accept    = 1'b0;
        w_mul_sq    = 1'b0;
        w_div_start = 1'b0;
        w_div_long  = 1'b0;
        w_div_in    = r_acc;
        w_out_load  = 1'b0;
        case (r_state)
            hlg_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                w_accept   = i_in_valid;
            end
            hlg_pkg::S_MUL_A: w_mul_sq = 1'b1;
            hlg_pkg::S_ACC: begin
                // gradient magnitude: |d| in range, else delta
                w_div_start = 1'b1;
                w_div_in    = ACC_W'(r_in_rng ? r_mag : w_delta_ext);
            end
            hlg_pkg::S_DIV_G: begin
                if (w_div_done && r_last) begin
                    w_div_start = 1'b1;
                    w_div_long  = 1'b1;
                end
            end
            hlg_pkg::S_OUT: w_out_load = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hlg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- config registers ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= hlg_pkg::DELTA_RESET;
            r_rows  <= hlg_pkg::ROWS_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == hlg_pkg::CFG_HUBER_DELTA) begin
                r_delta <= i_cfg_data[DELTA_W-1:0];
            end else if (i_cfg_index == hlg_pkg::CFG_BATCH_ROWS) begin
                r_rows <= i_cfg_data[ROWS_W-1:0];
            end
        end
    end

    // ---------------- difference and magnitude ----------------
    always_comb begin
        w_raw = $signed({r_pred[IO_W-1], r_pred}) - $signed({r_tgt[IO_W-1], r_tgt});
        if (w_raw > D_MAX) begin
            w_d = D_MAX;
        end else if (w_raw < D_MIN) begin
            w_d = D_MIN;
        end else begin
            w_d = w_raw;
        end
        w_abs = w_d[IO_W] ? -w_d : w_d;
    end

    // ---------------- shared multiplier ----------------
    always_comb begin
        if (w_mul_sq) begin
            w_mul_a = r_in_rng ? r_mag : w_delta_ext;
            w_mul_b = r_mag;
        end else begin
            w_mul_a = w_delta_ext;
            w_mul_b = w_delta_ext;
        end
    end

    hlg_mul #(
        .W (MUL_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // ---------------- element loss and accumulate ----------------
    always_comb begin
        // in range: d^2; else 2*delta*|d| - delta^2 (w_prod holds delta^2)
        w_full = r_in_rng ? {1'b0, r_p1} : ({r_p1, 1'b0} - {1'b0, w_prod});
        w_shr  = w_full >> (FRAC_BITS + 1);
        w_sum  = {1'b0, r_acc} + (ACC_W+1)'(r_elem);
    end

    // ---------------- shared divider ----------------
    hlg_div #(
        .DIVIDEND_W (ACC_W),
        .DIVISOR_W  (ROWS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_long     (w_div_long),
        .i_dividend (w_div_in),
        .i_divisor  (r_rows),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // restore the sign of the gradient quotient, then saturate
    always_comb begin
        w_gs = r_neg ? -$signed({1'b0, w_quo[IO_W-1:0]}) : $signed({1'b0, w_quo[IO_W-1:0]});
        if (w_gs > D_MAX) begin
            w_gsat = D_MAX;
        end else if (w_gs < D_MIN) begin
            w_gsat = D_MIN;
        end else begin
            w_gsat = w_gs;
        end
    end

    // ---------------- working registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pred <= i_prediction;
            r_tgt  <= i_target;
            r_last <= i_last_in_batch;
        end
        if (r_state == hlg_pkg::S_DIFF) begin
            r_neg    <= w_d[IO_W];
            r_mag    <= w_abs[MUL_W-1:0];
            r_in_rng <= (w_abs[MUL_W-1:0] <= w_delta_ext);
        end
        if (r_state == hlg_pkg::S_MUL_B) begin
            r_p1 <= w_prod;
        end
        if (r_state == hlg_pkg::S_ELEM) begin
            r_elem <= (w_shr > ELEM_MAX) ? ELEM_MAX[LOSS_W-1:0] : w_shr[LOSS_W-1:0];
        end
        if (r_state == hlg_pkg::S_DIV_G && w_div_done) begin
            r_grad <= w_gsat[IO_W-1:0];
        end
    end

    // accumulator: saturate on overflow, clear after the last word's divide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_state == hlg_pkg::S_ACC) begin
            r_acc <= w_sum[ACC_W] ? {ACC_W{1'b1}} : w_sum[ACC_W-1:0];
        end else if (r_state == hlg_pkg::S_DIV_L && w_div_done) begin
            r_acc <= '0;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    logic [LOSS_W-1:0] r_loss;

    always_ff @(posedge i_clk) begin
        // batch loss: zero unless last, saturated to the 31-bit range
        if (r_state == hlg_pkg::S_DIV_G && w_div_done) begin
            r_loss <= '0;
        end else if (r_state == hlg_pkg::S_DIV_L && w_div_done) begin
            r_loss <= (|w_quo[ACC_W-1:LOSS_W]) ? LOSS_MAX : w_quo[LOSS_W-1:0];
        end
        if (w_out_load) begin
            r_out_grad <= r_grad;
            r_out_loss <= r_loss;
            r_out_last <= r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_gradient   = r_out_grad;
    assign o_batch_loss = r_out_loss;
    assign o_last_out   = r_out_last;

endmodule

`default_nettype wire
